// ===== src/ghgp_pkg.sv =====
// shared types, constants and the byte-wide crc-32 update
// for the gpt header guid patch block; no dependencies
`default_nettype none

package ghgp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned GUID_W     = 128;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  localparam int unsigned MIN_HEADER = 92;
  localparam int unsigned GUID_AT    = 56;
  localparam int unsigned GUID_LEN   = 16;
  localparam int unsigned CRC_AT     = 16;
  localparam int unsigned SIZE_AT    = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATCH_ENABLE  = 8'd0,
    CFG_GUID_LOW      = 8'd1,
    CFG_GUID_HIGH     = 8'd2,
    CFG_HEADER_LENGTH = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              patch_enable;
    logic [GUID_W-1:0] guid;
    logic [LEN_W-1:0]  header_length;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] header_byte;
  } beat_t;

  // reflected crc-32, one byte, bit at a time
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/ghgp_if.sv =====
// channel interfaces: header byte input, result output, config write
// depends on ghgp_pkg
`default_nettype none

interface ghgp_in_if;
  import ghgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  modport source(output valid, output header_byte, input ready);
  modport sink(input valid, input header_byte, output ready);
endinterface

interface ghgp_out_if;
  import ghgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_header;
  logic              crc_valid;
  logic [CRC_W-1:0]  crc_value;
  modport source(output valid, output out_byte, output end_of_header,
                 output crc_valid, output crc_value, input ready);
  modport sink(input valid, input out_byte, input end_of_header,
               input crc_valid, input crc_value, output ready);
endinterface

interface ghgp_cfg_if;
  import ghgp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ghgp_cfg_regs.sv =====
// configuration register file written over the cfg channel
// depends on ghgp_pkg and ghgp_cfg_if
`default_nettype none

module ghgp_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ghgp_cfg_if.sink      cfg_ch,
  output ghgp_pkg::cfg_t cfg
);
  import ghgp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_PATCH_ENABLE:  cfg_nxt.patch_enable = cfg_ch.data[0];
        CFG_GUID_LOW:      cfg_nxt.guid[CFG_DATA_W-1:0] = cfg_ch.data;
        CFG_GUID_HIGH:     cfg_nxt.guid[GUID_W-1:CFG_DATA_W] = cfg_ch.data;
        CFG_HEADER_LENGTH: cfg_nxt.header_length = cfg_ch.data[LEN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.patch_enable  <= 1'b0;
      cfg_r.guid          <= '0;
      cfg_r.header_length <= LEN_W'(MIN_HEADER);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ghgp_in_reg.sv =====
// input register stage for header byte beats
// depends on ghgp_pkg and ghgp_in_if
`default_nettype none

module ghgp_in_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ghgp_in_if.sink          in_ch,
  input  wire logic        dp_ready,
  output ghgp_pkg::beat_t  s1
);
  import ghgp_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  assign in_ch.ready = !vld_r || dp_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (dp_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.header_byte;
    end
  end

  assign s1.valid       = vld_r;
  assign s1.header_byte = byte_r;

endmodule

`default_nettype wire

// ===== src/ghgp_datapath.sv =====
// per-byte patch, size capture, crc update and result register
// depends on ghgp_pkg and ghgp_out_if
`default_nettype none

module ghgp_datapath #(
  parameter int MAX_HEADER_BYTES = 512
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ghgp_pkg::cfg_t  cfg,
  input  wire ghgp_pkg::beat_t s1,
  output logic                 dp_ready,
  ghgp_out_if.source           out_ch
);
  import ghgp_pkg::*;

  localparam int POS_W   = (MAX_HEADER_BYTES > 2) ? $clog2(MAX_HEADER_BYTES) : 1;
  localparam int CMP_W   = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam int LEN_CAP = (MAX_HEADER_BYTES < 1023) ? MAX_HEADER_BYTES : 1023;

  // stream state
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [CRC_W-1:0] crc_r,    crc_nxt;
  logic [CRC_W-1:0] crcmin_r, crcmin_nxt;
  logic [CRC_W-1:0] size_r,   size_nxt;

  // result register
  logic              out_vld_r;
  logic [BYTE_W-1:0] obyte_r,  obyte_nxt;
  logic              eoh_r,    eoh_nxt;
  logic              cv_r,     cv_nxt;
  logic [CRC_W-1:0]  cval_r,   cval_nxt;

  logic              fire;
  logic [LEN_W-1:0]  len1;
  logic [LEN_W-1:0]  eff_len;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  len_x;
  logic [CMP_W-1:0]  sz_off;
  logic [CMP_W-1:0]  g_off;
  logic              patched;
  logic              last;
  logic              in_size;
  logic              in_guid;
  logic              in_crcf;
  logic              size_ok;
  logic              crc_on;

  assign dp_ready = !out_vld_r || out_ch.ready;
  assign fire     = s1.valid && dp_ready;

  always_comb begin
    len1    = (cfg.header_length == '0) ? LEN_W'(1) : cfg.header_length;
    eff_len = (len1 > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len1;
    pos_x   = CMP_W'(pos_r);
    len_x   = CMP_W'(eff_len);
    patched = cfg.patch_enable && (eff_len >= LEN_W'(MIN_HEADER));
    last    = pos_x >= (len_x - CMP_W'(1));

    sz_off  = pos_x - CMP_W'(SIZE_AT);
    g_off   = pos_x - CMP_W'(GUID_AT);
    in_size = (pos_x >= CMP_W'(SIZE_AT)) && (pos_x < CMP_W'(SIZE_AT + 4));
    in_guid = (pos_x >= CMP_W'(GUID_AT)) && (pos_x < CMP_W'(GUID_AT + GUID_LEN));
    in_crcf = (pos_x >= CMP_W'(CRC_AT)) && (pos_x < CMP_W'(CRC_AT + 4));

    // little-endian size field capture
    size_nxt = size_r;
    if (in_size) begin
      size_nxt = size_r | (CRC_W'(s1.header_byte) << {sz_off[1:0], 3'b000});
    end

    obyte_nxt = s1.header_byte;
    if (patched) begin
      if (in_guid) begin
        obyte_nxt = cfg.guid[{g_off[3:0], 3'b000} +: BYTE_W];
      end else if (in_crcf) begin
        obyte_nxt = '0;
      end
    end

    size_ok = (size_nxt >= CRC_W'(MIN_HEADER)) && (size_nxt <= CRC_W'(eff_len));
    crc_on  = (pos_x < CMP_W'(MIN_HEADER)) || (size_ok && (CRC_W'(pos_x) < size_nxt));
    crc_nxt = crc_on ? crc_byte(crc_r, obyte_nxt) : crc_r;
    crcmin_nxt = (pos_x == CMP_W'(MIN_HEADER - 1)) ? crc_nxt : crcmin_r;

    eoh_nxt  = last;
    cv_nxt   = last && patched;
    cval_nxt = cv_nxt ? ~(size_ok ? crc_nxt : crcmin_nxt) : '0;
    pos_nxt  = last ? '0 : pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= CRC_INIT;
      crcmin_r  <= '0;
      size_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        if (last) begin
          pos_r    <= '0;
          crc_r    <= CRC_INIT;
          crcmin_r <= '0;
          size_r   <= '0;
        end else begin
          pos_r    <= pos_nxt;
          crc_r    <= crc_nxt;
          crcmin_r <= crcmin_nxt;
          size_r   <= size_nxt;
        end
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte_r <= obyte_nxt;
      eoh_r   <= eoh_nxt;
      cv_r    <= cv_nxt;
      cval_r  <= cval_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_byte      = obyte_r;
  assign out_ch.end_of_header = eoh_r;
  assign out_ch.crc_valid     = cv_r;
  assign out_ch.crc_value     = cval_r;

endmodule

`default_nettype wire

// ===== src/gpt_header_guid_patch_crc32.sv =====
// top level of the gpt header guid patch and crc-32 block
// depends on ghgp_pkg, ghgp_if, ghgp_cfg_regs, ghgp_in_reg, ghgp_datapath
`default_nettype none

// Streams a GPT header one byte per beat and returns one result beat per
// input beat. With patch_enable set and an effective length of at least 92,
// bytes 56..71 are replaced by the configured disk guid, bytes 16..19 go out
// as zero, and a reflected crc-32 (poly edb88320, init and final xor all
// ones) is run over the patched bytes. The crc covers the little-endian size
// field at bytes 12..15, or 92 bytes when that size is below 92 or beyond
// the header length. It is reported with crc_valid on the final beat of the
// header (end_of_header); a downstream writer stores it at offset 16. A
// header_length of 0 acts as 1, any value above MAX_HEADER_BYTES acts as
// MAX_HEADER_BYTES. Throughput is one byte per clock while out_ch.ready is
// high. An accepted beat sits in the input register, then goes through the
// byte-wide crc update into the result register, which drives the output
// until out_ch.ready takes it. The result register is backed by the input
// register, so one more byte is taken while a finished result waits on
// out_ch.ready. Config writes are always taken (cfg_ch.ready is tied high)
// and must only happen while no beat is in flight.
module gpt_header_guid_patch_crc32 #(
  parameter int MAX_HEADER_BYTES = 512
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ghgp_cfg_if.sink    cfg_ch,
  ghgp_in_if.sink     in_ch,
  ghgp_out_if.source  out_ch
);
  import ghgp_pkg::*;

  cfg_t  cfg;        // live register values
  beat_t s1;         // beat held in the input register
  logic  dp_ready;   // datapath can take the held beat

  // register file, writes land the cycle after the beat
  ghgp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register, frees up whenever the datapath advances
  ghgp_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dp_ready (dp_ready),
    .s1       (s1)
  );

  // patch, crc and result register
  ghgp_datapath #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1       (s1),
    .dp_ready (dp_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/ghgp_checker.sv =====
// port-level checks for the gpt header guid patch block, with bind
// depends on gpt_header_guid_patch_crc32 and ghgp_if
`default_nettype none

module ghgp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        end_of_header,
  input wire logic        crc_valid,
  input wire logic [31:0] crc_value
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(end_of_header) && $stable(crc_valid) && $stable(crc_value))
    else $error("result beat changed while stalled");

  // crc only on the final beat of a header
  a_crc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && crc_valid |-> end_of_header)
    else $error("crc_valid without end_of_header");

  // crc value zero when not reported
  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !crc_valid |-> crc_value == 32'd0)
    else $error("crc_value nonzero without crc_valid");

  // a result from an idle output comes from an input beat that went straight through the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input beat");

endmodule

bind gpt_header_guid_patch_crc32 ghgp_checker u_ghgp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .end_of_header (out_ch.end_of_header),
  .crc_valid     (out_ch.crc_valid),
  .crc_value     (out_ch.crc_value)
);

`default_nettype wire

// ===== sim/gpt_header_guid_patch_crc32_test.sv =====
// testbench for gpt_header_guid_patch_crc32: streams gpt headers through the block
// and checks every result beat against a cycle-free model of the patch and crc-32
// depends on ghgp_pkg, ghgp_if and the block's rtl
`timescale 1ns / 1ps

module gpt_header_guid_patch_crc32_test;
  import ghgp_pkg::*;

  localparam int MAX_BYTES   = 512;
  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS       = 1750;
  localparam int SETTLE_CYCLES = 8;

  // fill patterns for header bodies
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_header;
    logic              crc_valid;
    logic [CRC_W-1:0]  crc_value;
  } hdr_beat_t;

  // patch predictor plus the queue of result beats still owed by the block
  class patch_tracker;
    logic                 patch_en;
    logic [63:0]          guid_lo;
    logic [63:0]          guid_hi;
    logic [LEN_W-1:0]     hdr_len;
    logic [8:0]           pos;
    logic [CRC_W-1:0]     crc_run;
    logic [CRC_W-1:0]     crc_min;
    logic [CRC_W-1:0]     size_seen;
    hdr_beat_t            owed_beats[$];
    int                   errors;

    function new();
      patch_en = 1'b0;
      guid_lo  = '0;
      guid_hi  = '0;
      hdr_len  = LEN_W'(MIN_HEADER);
      errors   = 0;
      restart();
    endfunction

    function void restart();
      pos       = '0;
      crc_run   = CRC_INIT;
      crc_min   = '0;
      size_seen = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATCH_ENABLE:  patch_en = value[0];
        CFG_GUID_LOW:      guid_lo = value;
        CFG_GUID_HIGH:     guid_hi = value;
        CFG_HEADER_LENGTH: hdr_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // reflected crc-32, lsb first
    function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      int unsigned len;
      int unsigned p;
      int unsigned k;
      logic        patched;
      logic        last;
      logic        size_ok;
      logic [63:0] w;
      hdr_beat_t   e;
      len = hdr_len;
      if (len == 0) len = 1;
      if (len > MAX_BYTES) len = MAX_BYTES;
      p = pos;
      patched = patch_en && (len >= MIN_HEADER);
      last = (p >= len - 1);
      if (p >= SIZE_AT && p < SIZE_AT + 4)
        size_seen = size_seen | (CRC_W'(b) << (8 * (p - SIZE_AT)));
      e.out_byte = b;
      if (patched) begin
        if (p >= GUID_AT && p < GUID_AT + GUID_LEN) begin
          k = p - GUID_AT;
          w = (k < 8) ? guid_lo : guid_hi;
          e.out_byte = w[8 * (k % 8) +: 8];
        end else if (p >= CRC_AT && p < CRC_AT + 4) begin
          e.out_byte = '0;
        end
      end
      size_ok = (size_seen >= MIN_HEADER) && (size_seen <= len);
      if (p < MIN_HEADER || (size_ok && p < size_seen))
        crc_run = crc_step(crc_run, e.out_byte);
      if (p == MIN_HEADER - 1) crc_min = crc_run;
      e.end_of_header = last;
      e.crc_valid     = last && patched;
      e.crc_value     = (last && patched) ? ~(size_ok ? crc_run : crc_min) : '0;
      owed_beats.insert(owed_beats.size(), e);
      if (last) restart();
      else pos = pos + 1'b1;
    endfunction

    function void match_beat(hdr_beat_t got);
      hdr_beat_t e;
      if (owed_beats.size() == 0) begin
        $error("unexpected result beat, out_byte %h", got.out_byte);
        errors++;
        return;
      end
      e = owed_beats.pop_front();
      if (got.out_byte !== e.out_byte) begin
        $error("out_byte expected %h actual %h", e.out_byte, got.out_byte);
        errors++;
      end
      if (got.end_of_header !== e.end_of_header) begin
        $error("end_of_header expected %b actual %b", e.end_of_header, got.end_of_header);
        errors++;
      end
      if (got.crc_valid !== e.crc_valid) begin
        $error("crc_valid expected %b actual %b", e.crc_valid, got.crc_valid);
        errors++;
      end
      if (got.crc_value !== e.crc_value) begin
        $error("crc_value expected %h actual %h", e.crc_value, got.crc_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  ghgp_cfg_if cfg_ch();
  ghgp_in_if  in_ch();
  ghgp_out_if out_ch();

  gpt_header_guid_patch_crc32 #(
    .MAX_HEADER_BYTES(MAX_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  patch_tracker sb;
  bit           quiet     = 1'b0;  // no random idling on either side while set
  int           hold_left = 0;     // receiver hold-off, counted down by the receiver
  int           bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // sample all three channels at the rising edge; inputs only move at the falling edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.take_byte(in_ch.header_byte);
      if (out_ch.valid && out_ch.ready)
        sb.match_beat(hdr_beat_t'{out_ch.out_byte, out_ch.end_of_header,
                                  out_ch.crc_valid, out_ch.crc_value});
    end
  end

  // result side: random back-pressure, or a long counted hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // offer one header byte; leaves valid high so back-to-back beats need no toggle
  task automatic put_byte(logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.header_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  // n bytes of header, size field at bytes 12..15, body as the fill says
  task automatic send_header(int n, logic [31:0] size, int fill);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom());
      endcase
      if (i >= SIZE_AT && i < SIZE_AT + 4) b = size[8 * (i - SIZE_AT) +: 8];
      put_byte(b);
    end
  endtask

  // stop offering and wait until every owed beat has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.owed_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // all four registers; unused upper data bits are random so they must be ignored
  task automatic configure(logic pe, logic [63:0] lo, logic [63:0] hi, logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] pe_word;
    logic [CFG_DATA_W-1:0] len_word;
    pe_word  = {$urandom(), $urandom()};
    len_word = {$urandom(), $urandom()};
    pe_word[0] = pe;
    len_word[LEN_W-1:0] = len;
    write_reg(CFG_PATCH_ENABLE, pe_word);
    write_reg(CFG_GUID_LOW, lo);
    write_reg(CFG_GUID_HIGH, hi);
    write_reg(CFG_HEADER_LENGTH, len_word);
  endtask

  function automatic int eff_len(logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > MAX_BYTES) return MAX_BYTES;
    return int'(l);
  endfunction

  function automatic logic [63:0] rand_guid();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int               n;
    int               k;
    int               s;
    int               r;
    logic             pe;
    logic [LEN_W-1:0] len;
    logic [31:0]      size;

    sb = new();
    in_ch.valid       = 1'b0;
    in_ch.header_byte = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;

    // single synchronous reset at the start
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // reset values: patching off, 92-byte header passes through
    send_header(92, 92, FILL_RANDOM);
    settle();

    // minimum header, guid all ones in the high half, ones body
    configure(1'b1, '0, '1, 10'(MIN_HEADER));
    send_header(92, 92, FILL_ONES);
    settle();

    // length beyond the maximum clamps to it, largest size field, zero body;
    // receiver holds off while the sender keeps offering, then no idling at all
    configure(1'b1, '1, '0, 10'd1023);
    quiet = 1'b1;
    hold_left = HOLD_CYCLES;
    send_header(MAX_BYTES, MAX_BYTES, FILL_ZERO);
    settle();
    quiet = 1'b0;

    // size field inside the header
    configure(1'b1, rand_guid(), rand_guid(), 10'd130);
    send_header(130, 110, FILL_RANDOM);
    settle();

    // size below minimum, size beyond length, size all ones: crc falls back to 92 bytes
    configure(1'b1, rand_guid(), rand_guid(), 10'd100);
    send_header(100, 40, FILL_RANDOM);
    send_header(100, 300, FILL_RANDOM);
    send_header(100, 32'hFFFF_FFFF, FILL_RANDOM);
    settle();

    // length one short of the minimum: no patch even with enable set
    configure(1'b1, rand_guid(), rand_guid(), 10'd91);
    send_header(91, 91, FILL_RANDOM);
    settle();

    // one-byte headers: every beat is final
    configure(1'b1, rand_guid(), rand_guid(), 10'd1);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'($urandom()));
    settle();

    // zero length acts as one
    configure(1'b1, rand_guid(), rand_guid(), 10'd0);
    put_byte(8'hA5);
    put_byte(8'h5A);
    settle();

    // patching off on a full-size header
    configure(1'b0, rand_guid(), rand_guid(), 10'd100);
    send_header(100, 100, FILL_RANDOM);
    settle();

    // length lowered below the position mid-header: next byte ends it, unpatched
    configure(1'b1, rand_guid(), rand_guid(), 10'd200);
    send_header(100, 150, FILL_RANDOM);
    settle();
    write_reg(CFG_HEADER_LENGTH, 64'd60);
    put_byte(8'($urandom()));
    settle();

    // same, still long enough to patch but now shorter than the size field
    configure(1'b1, rand_guid(), rand_guid(), 10'd200);
    send_header(110, 150, FILL_RANDOM);
    settle();
    write_reg(CFG_HEADER_LENGTH, 64'd100);
    put_byte(8'($urandom()));
    settle();

    // ---- random part: phases of one config and a few headers each ----
    while (bytes_sent < ITEMS) begin
      pe = ($urandom_range(0, 99) < 80);
      r = $urandom_range(0, 99);
      if (r < 70) len = 10'($urandom_range(92, 160));
      else if (r < 76) len = 10'($urandom_range(161, 300));
      else if (r < 78) len = 10'(MAX_BYTES);
      else if (r < 80) len = 10'($urandom_range(513, 1023));
      else if (r < 92) len = 10'($urandom_range(1, 91));
      else len = 10'd0;
      configure(pe, rand_guid(), rand_guid(), len);
      n = eff_len(len);

      repeat ($urandom_range(1, 3)) begin
        s = $urandom_range(0, 99);
        if (n >= MIN_HEADER && s < 70) size = $urandom_range(MIN_HEADER, n);
        else if (s < 78) size = n;
        else if (s < 86) size = $urandom_range(0, MIN_HEADER - 1);
        else if (s < 94) size = $urandom_range(n + 1, n + 1000);
        else size = $urandom();

        if (n > 2 && $urandom_range(0, 99) < 6) begin
          // cut the header short by lowering the length while idle
          k = $urandom_range(1, n - 1);
          send_header(k, size, FILL_RANDOM);
          settle();
          write_reg(CFG_HEADER_LENGTH, 64'($urandom_range(1, k + 1)));
          put_byte(8'($urandom()));
          settle();
          write_reg(CFG_HEADER_LENGTH, 64'(len));
        end else begin
          r = $urandom_range(0, 19);
          send_header(n, size, (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM);
        end
      end
      settle();
    end

    quiet = 1'b0;
    settle();
    if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
